>>> design/priority_fifo_expiry_accumulator_unit_defines.svh
// Assertion macros for the priority FIFO expiry accumulator.
// Included by the RTL files that carry concurrent checks; uses clk and arst_n of the includer.
`ifndef PRIORITY_FIFO_EXPIRY_ACCUMULATOR_UNIT_DEFINES_SVH
`define PRIORITY_FIFO_EXPIRY_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define PFEA_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PFEA_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PFEA_CHECK(name, prop, msg)
`define PFEA_NEVER(name, expr, msg)
`endif
`endif

>>> design/pfea_pkg.sv
// Shared constants, codes and types for the priority FIFO expiry accumulator.
// No dependencies.
`default_nettype none
package pfea_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QUEUES  = 3;
	localparam int SLOTS       = QUEUE_DEPTH * NUM_QUEUES;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int ADDR_W = $clog2(SLOTS);

	localparam int VAL_W   = 32;
	localparam int TIME_W  = 32;
	localparam int LIFE_W  = 16;
	localparam int QID_W   = 2;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;
	localparam int ENTRY_W = VAL_W + TIME_W + LIFE_W;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	// Decision for one operation, from the queue controller to the datapath.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [QID_W-1:0]  qid;
		logic [QIDX_W-1:0] qidx;
		logic [OCC_W-1:0]  occ;
		logic              hit;
		logic              ram_we;
		logic              ram_re;
		logic [ADDR_W-1:0] addr;
	} dec_t;
endpackage
`default_nettype wire

>>> design/priority_fifo_expiry_accumulator_unit.sv
// Top level of the strict-priority multi-FIFO with entry expiry and per-queue sums.
// Depends on pfea_pkg, pfea_ctrl, pfea_ram and the assertion macro header.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------------
//  in      | in_valid / in_stall | opcode, queue_sel, push_value, lifetime_ms, now_ms
//  out     | out_valid/out_stall | status, queue_id, out_value, expired, queue_sum,
//          |                     | occupancy
//
// One operation per cycle unless a stalled result holds stage one, one result per operation:
// the entry RAM read is registered, so expiry and the sum update land in the second stage.
// Reset (arst_n) clears ring pointers, fill counts, sums and valid flags; the entry RAM is
// not cleared, since only written slots are ever read.
// A stalled result holds the output register; the input stalls only when stage one is
// occupied and cannot move forward.
`default_nettype none
`include "priority_fifo_expiry_accumulator_unit_defines.svh"
module priority_fifo_expiry_accumulator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               opcode,
	input  logic [pfea_pkg::QID_W-1:0]         queue_sel,
	input  logic signed [pfea_pkg::VAL_W-1:0]  push_value,
	input  logic [pfea_pkg::LIFE_W-1:0]        lifetime_ms,
	input  logic [pfea_pkg::TIME_W-1:0]        now_ms,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pfea_pkg::STAT_W-1:0]        status,
	output logic [pfea_pkg::QID_W-1:0]         queue_id,
	output logic signed [pfea_pkg::VAL_W-1:0]  out_value,
	output logic                               expired,
	output logic signed [pfea_pkg::VAL_W-1:0]  queue_sum,
	output logic [pfea_pkg::OCC_W-1:0]         occupancy
);
	localparam int VW = pfea_pkg::VAL_W;
	localparam int TW = pfea_pkg::TIME_W;
	localparam int LW = pfea_pkg::LIFE_W;

	// Handshake
	logic in_xfer;
	logic out_free;
	logic adv_s1;

	// Queue controller decision for the item on the input
	pfea_pkg::dec_t dec;

	// Stage one: decision plus the time needed for the expiry check
	logic                          valid_s1;
	logic [pfea_pkg::STAT_W-1:0]   status_s1;
	logic [pfea_pkg::QID_W-1:0]    qid_s1;
	logic [pfea_pkg::QIDX_W-1:0]   qidx_s1;
	logic [pfea_pkg::OCC_W-1:0]    occ_s1;
	logic                          hit_s1;
	logic [TW-1:0]                 now_s1;

	// Entry RAM
	logic [pfea_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [pfea_pkg::ENTRY_W-1:0]  ram_rdata;
	logic [VW-1:0]                 rd_value;
	logic [TW-1:0]                 rd_created;
	logic [LW-1:0]                 rd_life;

	// Stage two: expiry and sum
	logic [TW-1:0]                 elapsed;
	logic                          late;
	logic [VW-1:0]                 cur_sum;
	logic [VW-1:0]                 new_sum;
	logic [VW-1:0]                 sums_q [pfea_pkg::NUM_QUEUES];

	// Result register
	logic                          out_valid_q;
	logic [pfea_pkg::STAT_W-1:0]   status_q;
	logic [pfea_pkg::QID_W-1:0]    queue_id_q;
	logic [VW-1:0]                 value_q;
	logic                          expired_q;
	logic [VW-1:0]                 sum_q;
	logic [pfea_pkg::OCC_W-1:0]    occ_q;

	// Stage one moves whenever the result register is empty or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	// Decide and update pointers at the transfer; the RAM access goes out the same cycle.
	pfea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_xfer),
		.req_op    (opcode),
		.req_sel   (queue_sel),
		.dec       (dec)
	);

	assign ram_wdata = {$unsigned(push_value), now_ms, lifetime_ms};

	pfea_ram #(
		.WIDTH (pfea_pkg::ENTRY_W),
		.DEPTH (pfea_pkg::SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (in_xfer && dec.ram_we),
		.waddr (dec.addr),
		.wdata (ram_wdata),
		.re    (in_xfer && dec.ram_re),
		.raddr (dec.addr),
		.rdata (ram_rdata)
	);

	// Read data only changes on a pop transfer, so it holds while stage one stalls.
	assign rd_value   = ram_rdata[pfea_pkg::ENTRY_W-1 -: VW];
	assign rd_created = ram_rdata[LW +: TW];
	assign rd_life    = ram_rdata[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_s1 <= dec.status;
			qid_s1    <= dec.qid;
			qidx_s1   <= dec.qidx;
			occ_s1    <= dec.occ;
			hit_s1    <= dec.hit;
			now_s1    <= now_ms;
		end
	end

	// Elapsed time wraps modulo 2^32; equal to the lifetime still counts as live.
	always_comb begin
		elapsed = now_s1 - rd_created;
		late    = elapsed > TW'(rd_life);
		cur_sum = sums_q[qidx_s1];
		new_sum = late ? cur_sum : cur_sum + rd_value;
	end

	// Accumulate only on a served pop whose entry has not expired.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < pfea_pkg::NUM_QUEUES; q++) begin
				sums_q[q] <= '0;
			end
		end else if (adv_s1 && hit_s1) begin
			sums_q[qidx_s1] <= new_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Load the result; pushes and empty pops carry zero value, flag and sum.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q   <= status_s1;
			queue_id_q <= qid_s1;
			occ_q      <= occ_s1;
			if (hit_s1) begin
				value_q   <= rd_value;
				expired_q <= late;
				sum_q     <= new_sum;
			end else begin
				value_q   <= '0;
				expired_q <= 1'b0;
				sum_q     <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign queue_id  = queue_id_q;
	assign out_value = $signed(value_q);
	assign expired   = expired_q;
	assign queue_sum = $signed(sum_q);
	assign occupancy = occ_q;

	`PFEA_CHECK(a_pop_hit_reaches_s1, (in_xfer && dec.ram_re) |=> (valid_s1 && hit_s1), "pop hit lost before stage one")
	`PFEA_CHECK(a_empty_is_zero, (out_valid && status == pfea_pkg::STATUS_EMPTY) |-> (queue_id == '0 && occupancy == '0 && out_value == '0 && queue_sum == '0 && !expired), "empty pop result not cleared")
	`PFEA_CHECK(a_reject_is_zero, (out_valid && status == pfea_pkg::STATUS_FULL) |-> (out_value == '0 && queue_sum == '0 && !expired), "rejected push carries data")
	`PFEA_NEVER(a_expired_needs_done, out_valid && expired && status != pfea_pkg::STATUS_DONE, "expired flag without a served pop")
endmodule
`default_nettype wire

>>> design/pfea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> design/pfea_ctrl.sv
// Queue controller: ring pointers, fill counts and the strict-priority pick.
// Depends on pfea_pkg.
`default_nettype none
module pfea_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_op,
	input  logic [pfea_pkg::QID_W-1:0] req_sel,
	output pfea_pkg::dec_t             dec
);
	localparam int PW = pfea_pkg::PTR_W;
	localparam int FW = pfea_pkg::FILL_W;
	localparam int IW = pfea_pkg::QIDX_W;
	localparam int AW = pfea_pkg::ADDR_W;

	logic [PW-1:0] head_q [pfea_pkg::NUM_QUEUES];
	logic [FW-1:0] fill_q [pfea_pkg::NUM_QUEUES];

	logic          sel_ok;
	logic [IW-1:0] sidx;
	logic [IW-1:0] pidx;
	logic          found;
	logic [FW-1:0] sel_fill;
	logic [PW-1:0] sel_head;
	logic [FW-1:0] pop_fill;
	logic [PW-1:0] pop_head;
	logic [PW:0]   tail_sum;
	logic [PW-1:0] tail;
	logic [PW-1:0] head_next;

	always_comb begin
		sel_ok   = 32'(req_sel) < 32'(pfea_pkg::NUM_QUEUES);
		sidx     = IW'(req_sel);
		sel_fill = '0;
		sel_head = '0;
		if (sel_ok) begin
			sel_fill = fill_q[sidx];
			sel_head = head_q[sidx];
		end

		// lowest-numbered non-empty queue wins
		found = 1'b0;
		pidx  = '0;
		for (int q = pfea_pkg::NUM_QUEUES - 1; q >= 0; q--) begin
			if (fill_q[q] != '0) begin
				found = 1'b1;
				pidx  = IW'(q);
			end
		end
		pop_fill = fill_q[pidx];
		pop_head = head_q[pidx];
		head_next = (pop_head == PW'(pfea_pkg::QUEUE_DEPTH - 1)) ? '0 : pop_head + PW'(1);

		tail_sum = (PW+1)'(sel_head) + (PW+1)'(sel_fill);
		tail = (tail_sum >= (PW+1)'(pfea_pkg::QUEUE_DEPTH))
			? PW'(tail_sum - (PW+1)'(pfea_pkg::QUEUE_DEPTH)) : PW'(tail_sum);

		dec = '0;
		if (req_op == pfea_pkg::OP_PUSH) begin
			dec.qid  = req_sel;
			dec.qidx = sidx;
			if (!sel_ok) begin
				dec.status = pfea_pkg::STATUS_FULL;
			end else if (sel_fill >= FW'(pfea_pkg::QUEUE_DEPTH)) begin
				dec.status = pfea_pkg::STATUS_FULL;
				dec.occ    = pfea_pkg::OCC_W'(sel_fill);
			end else begin
				dec.status = pfea_pkg::STATUS_DONE;
				dec.ram_we = 1'b1;
				dec.addr   = AW'(sidx) * AW'(pfea_pkg::QUEUE_DEPTH) + AW'(tail);
				dec.occ    = pfea_pkg::OCC_W'(sel_fill + FW'(1));
			end
		end else if (found) begin
			dec.status = pfea_pkg::STATUS_DONE;
			dec.qid    = pfea_pkg::QID_W'(pidx);
			dec.qidx   = pidx;
			dec.hit    = 1'b1;
			dec.ram_re = 1'b1;
			dec.addr   = AW'(pidx) * AW'(pfea_pkg::QUEUE_DEPTH) + AW'(pop_head);
			dec.occ    = pfea_pkg::OCC_W'(pop_fill - FW'(1));
		end else begin
			dec.status = pfea_pkg::STATUS_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < pfea_pkg::NUM_QUEUES; q++) begin
				head_q[q] <= '0;
				fill_q[q] <= '0;
			end
		end else if (req_valid) begin
			if (dec.ram_we) begin
				fill_q[sidx] <= sel_fill + FW'(1);
			end
			if (dec.ram_re) begin
				fill_q[pidx] <= pop_fill - FW'(1);
				head_q[pidx] <= head_next;
			end
		end
	end
endmodule
`default_nettype wire
